/* rtl/lcc_pkg.sv */
`timescale 1ns / 1ps

package lcc_pkg;

    localparam int ADDRESS_BITS    = 32;
    localparam int BLOCK_ADDRESS_W = 32;
    localparam int LBA_W = (ADDRESS_BITS < BLOCK_ADDRESS_W) ? ADDRESS_BITS : BLOCK_ADDRESS_W;

    localparam int CYL_COUNT_W  = 16;
    localparam int HEAD_COUNT_W = 8;
    localparam int SPT_W        = 6;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CYL_COUNT_W-1:0]  CYL_COUNT_RST  = 16'd1024;
    localparam logic [HEAD_COUNT_W-1:0] HEAD_COUNT_RST = 8'd16;
    localparam logic [SPT_W-1:0]        SPT_RST        = 6'd63;

    localparam int PER_CYL_W = HEAD_COUNT_W + SPT_W;
    localparam logic [PER_CYL_W-1:0] PER_CYL_RST = PER_CYL_W'(16 * 63);

    localparam int CYL_STEPS  = 4;
    localparam int CYL_STAGES = (LBA_W + CYL_STEPS - 1) / CYL_STEPS;
    localparam int CYL_QW     = CYL_STAGES * CYL_STEPS;
    localparam int CYL_REM_W  = PER_CYL_W + 1;

    localparam int HD_QW     = HEAD_COUNT_W;
    localparam int HD_STEPS  = 4;
    localparam int HD_STAGES = HD_QW / HD_STEPS;
    localparam int HD_REM_W  = SPT_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CYL_COUNT  = 2'd0,
        CFG_HEAD_COUNT = 2'd1,
        CFG_SPT        = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [CYL_REM_W-1:0] rem;
        logic [CYL_QW-1:0]    quo;
    } t_cyl_work;

    typedef struct packed {
        logic [CYL_QW-1:0]   cyl;
        logic [HD_REM_W-1:0] rem;
        logic [HD_QW-1:0]    quo;
    } t_hd_work;

endpackage

/* rtl/lcc_lba_if.sv */
`timescale 1ns / 1ps

interface lcc_lba_if;
    logic                                valid;
    logic                                ready;
    logic [lcc_pkg::BLOCK_ADDRESS_W-1:0] block_address;

    modport source (output valid, output block_address, input ready);
    modport sink (input valid, input block_address, output ready);
endinterface

/* rtl/lcc_chs_if.sv */
`timescale 1ns / 1ps

interface lcc_chs_if;
    logic                             valid;
    logic                             ready;
    logic [lcc_pkg::CYL_COUNT_W-1:0]  cylinder;
    logic [lcc_pkg::HEAD_COUNT_W-1:0] head;
    logic [lcc_pkg::SPT_W-1:0]        sector;
    logic                             clamped;

    modport source (output valid, output cylinder, output head, output sector,
                    output clamped, input ready);
    modport sink (input valid, input cylinder, input head, input sector,
                  input clamped, output ready);
endinterface

/* rtl/lcc_cfg_if.sv */
`timescale 1ns / 1ps

interface lcc_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcc_pkg::CFG_INDEX_W-1:0] index;
    logic [lcc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/lba_to_chs_geometry_converter.sv */
`timescale 1ns / 1ps

// LBA to CHS translation for a configured disk geometry.
// i_lba carries one logical block address per beat; o_chs returns one
// cylinder/head/sector/clamped beat for each, in order. i_cfg writes the
// geometry: index 0 cylinder count, 1 head count, 2 sectors per track;
// other indexes are dropped. Write only while no address is in flight.
// The path runs through 8 stages of the cylinder divider at 4 quotient
// bits each, 2 stages of the head divider and 1 output register. It
// takes one beat per cycle while o_chs does not stall, set by the
// pipelined restoring dividers.
// Reset (synchronous, active low) empties every stage and loads the
// geometry 1024/16/63. When o_chs stalls, each stage holds its beat and
// empty stages upstream keep filling, so i_lba stays ready until the
// pipe is full. Addresses whose cylinder passes the count, or any
// geometry with zero heads or sectors, return the geometry itself with
// clamped set.
module lba_to_chs_geometry_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcc_cfg_if.sink    i_cfg,
    lcc_lba_if.sink    i_lba,
    lcc_chs_if.source  o_chs
);

    localparam int NCS = lcc_pkg::CYL_STAGES;
    localparam int NHS = lcc_pkg::HD_STAGES;

    logic [lcc_pkg::CYL_COUNT_W-1:0]  r_cyl_count, n_cyl_count;
    logic [lcc_pkg::HEAD_COUNT_W-1:0] r_head_count, n_head_count;
    logic [lcc_pkg::SPT_W-1:0]        r_spt, n_spt;
    logic [lcc_pkg::PER_CYL_W-1:0]    r_per_cyl, n_per_cyl;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cyl_count  = r_cyl_count;
        n_head_count = r_head_count;
        n_spt        = r_spt;
        n_per_cyl    = r_per_cyl;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lcc_pkg::CFG_CYL_COUNT: begin
                    n_cyl_count = i_cfg.data[lcc_pkg::CYL_COUNT_W-1:0];
                end
                lcc_pkg::CFG_HEAD_COUNT: begin
                    n_head_count = i_cfg.data[lcc_pkg::HEAD_COUNT_W-1:0];
                    n_per_cyl    = lcc_pkg::PER_CYL_W'(n_head_count)
                                 * lcc_pkg::PER_CYL_W'(r_spt);
                end
                lcc_pkg::CFG_SPT: begin
                    n_spt     = i_cfg.data[lcc_pkg::SPT_W-1:0];
                    n_per_cyl = lcc_pkg::PER_CYL_W'(r_head_count)
                              * lcc_pkg::PER_CYL_W'(n_spt);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cyl_count  <= lcc_pkg::CYL_COUNT_RST;
            r_head_count <= lcc_pkg::HEAD_COUNT_RST;
            r_spt        <= lcc_pkg::SPT_RST;
            r_per_cyl    <= lcc_pkg::PER_CYL_RST;
        end else begin
            r_cyl_count  <= n_cyl_count;
            r_head_count <= n_head_count;
            r_spt        <= n_spt;
            r_per_cyl    <= n_per_cyl;
        end
    end

    // cylinder divider: LBA / (heads * sectors)
    logic               cyl_valid [0:NCS];
    logic               cyl_ready [0:NCS];
    lcc_pkg::t_cyl_work cyl_work  [0:NCS];

    assign cyl_valid[0]     = i_lba.valid;
    assign i_lba.ready      = cyl_ready[0];
    assign cyl_work[0].rem  = '0;
    assign cyl_work[0].quo  =
        lcc_pkg::CYL_QW'(i_lba.block_address[lcc_pkg::LBA_W-1:0]);

    for (genvar g = 0; g < NCS; g++) begin : g_cyl
        lcc_cyl_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (cyl_valid[g]),
            .o_ready   (cyl_ready[g]),
            .i_work    (cyl_work[g]),
            .i_divisor (r_per_cyl),
            .o_valid   (cyl_valid[g+1]),
            .i_ready   (cyl_ready[g+1]),
            .o_work    (cyl_work[g+1])
        );
    end

    // head divider: remainder / sectors; quotient fits in 8 bits
    logic              hd_valid [0:NHS];
    logic              hd_ready [0:NHS];
    lcc_pkg::t_hd_work hd_work  [0:NHS];

    assign hd_valid[0]      = cyl_valid[NCS];
    assign cyl_ready[NCS]   = hd_ready[0];
    assign hd_work[0].cyl   = cyl_work[NCS].quo;
    assign hd_work[0].rem   = lcc_pkg::HD_REM_W'(
        cyl_work[NCS].rem[lcc_pkg::PER_CYL_W-1:lcc_pkg::HD_QW]);
    assign hd_work[0].quo   = cyl_work[NCS].rem[lcc_pkg::HD_QW-1:0];

    for (genvar g = 0; g < NHS; g++) begin : g_hd
        lcc_hd_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (hd_valid[g]),
            .o_ready   (hd_ready[g]),
            .i_work    (hd_work[g]),
            .i_divisor (r_spt),
            .o_valid   (hd_valid[g+1]),
            .i_ready   (hd_ready[g+1]),
            .o_work    (hd_work[g+1])
        );
    end

    // clamp and output register
    logic                             r_out_valid;
    logic [lcc_pkg::CYL_COUNT_W-1:0]  r_cylinder, n_cylinder;
    logic [lcc_pkg::HEAD_COUNT_W-1:0] r_head, n_head;
    logic [lcc_pkg::SPT_W-1:0]        r_sector, n_sector;
    logic                             r_clamped, n_clamped;
    logic                             out_take;

    assign hd_ready[NHS] = !r_out_valid || o_chs.ready;
    assign out_take      = hd_valid[NHS] && hd_ready[NHS];

    always_comb begin
        n_clamped = (r_per_cyl == '0)
                 || (hd_work[NHS].cyl > lcc_pkg::CYL_QW'(r_cyl_count));
        if (n_clamped) begin
            n_cylinder = r_cyl_count;
            n_head     = r_head_count;
            n_sector   = r_spt;
        end else begin
            n_cylinder = hd_work[NHS].cyl[lcc_pkg::CYL_COUNT_W-1:0];
            n_head     = hd_work[NHS].quo;
            n_sector   = hd_work[NHS].rem[lcc_pkg::SPT_W-1:0] + lcc_pkg::SPT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (hd_ready[NHS]) begin
            r_out_valid <= hd_valid[NHS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take) begin
            r_cylinder <= n_cylinder;
            r_head     <= n_head;
            r_sector   <= n_sector;
            r_clamped  <= n_clamped;
        end
    end

    assign o_chs.valid    = r_out_valid;
    assign o_chs.cylinder = r_cylinder;
    assign o_chs.head     = r_head;
    assign o_chs.sector   = r_sector;
    assign o_chs.clamped  = r_clamped;

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chs.valid && !o_chs.clamped |-> o_chs.sector != '0 && o_chs.sector <= r_spt)
        else $error("sector outside geometry");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chs.valid && !o_chs.clamped |-> o_chs.head < r_head_count)
        else $error("head outside geometry");

    a_cyl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chs.valid && !o_chs.clamped |-> o_chs.cylinder <= r_cyl_count)
        else $error("unclamped cylinder beyond count");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_lba.ready)
        else $error("input blocked with empty output register");

endmodule

/* rtl/lcc_cyl_stage.sv */
`timescale 1ns / 1ps

module lcc_cyl_stage (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  lcc_pkg::t_cyl_work               i_work,
    input  logic [lcc_pkg::PER_CYL_W-1:0]    i_divisor,
    output logic                             o_valid,
    input  logic                             i_ready,
    output lcc_pkg::t_cyl_work               o_work
);

    logic                             r_valid;
    lcc_pkg::t_cyl_work               r_work;
    lcc_pkg::t_cyl_work               n_work;
    logic [lcc_pkg::CYL_REM_W-1:0]    c_rem;
    logic [lcc_pkg::CYL_REM_W-1:0]    c_shift;
    logic [lcc_pkg::CYL_REM_W-1:0]    c_div;
    logic [lcc_pkg::CYL_QW-1:0]       c_quo;

    // restoring division, CYL_STEPS quotient bits per beat
    always_comb begin
        c_div = lcc_pkg::CYL_REM_W'(i_divisor);
        c_rem = i_work.rem;
        c_quo = i_work.quo;
        c_shift = '0;
        for (int k = 0; k < lcc_pkg::CYL_STEPS; k++) begin
            c_shift = {c_rem[lcc_pkg::CYL_REM_W-2:0], c_quo[lcc_pkg::CYL_QW-1]};
            c_quo   = {c_quo[lcc_pkg::CYL_QW-2:0], 1'b0};
            if (c_shift >= c_div) begin
                c_rem    = c_shift - c_div;
                c_quo[0] = 1'b1;
            end else begin
                c_rem = c_shift;
            end
        end
        n_work.rem = c_rem;
        n_work.quo = c_quo;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

/* rtl/lcc_hd_stage.sv */
`timescale 1ns / 1ps

module lcc_hd_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  lcc_pkg::t_hd_work            i_work,
    input  logic [lcc_pkg::SPT_W-1:0]    i_divisor,
    output logic                         o_valid,
    input  logic                         i_ready,
    output lcc_pkg::t_hd_work            o_work
);

    logic                            r_valid;
    lcc_pkg::t_hd_work               r_work;
    lcc_pkg::t_hd_work               n_work;
    logic [lcc_pkg::HD_REM_W-1:0]    c_rem;
    logic [lcc_pkg::HD_REM_W-1:0]    c_shift;
    logic [lcc_pkg::HD_REM_W-1:0]    c_div;
    logic [lcc_pkg::HD_QW-1:0]       c_quo;

    always_comb begin
        c_div = lcc_pkg::HD_REM_W'(i_divisor);
        c_rem = i_work.rem;
        c_quo = i_work.quo;
        c_shift = '0;
        for (int k = 0; k < lcc_pkg::HD_STEPS; k++) begin
            c_shift = {c_rem[lcc_pkg::HD_REM_W-2:0], c_quo[lcc_pkg::HD_QW-1]};
            c_quo   = {c_quo[lcc_pkg::HD_QW-2:0], 1'b0};
            if (c_shift >= c_div) begin
                c_rem    = c_shift - c_div;
                c_quo[0] = 1'b1;
            end else begin
                c_rem = c_shift;
            end
        end
        n_work.cyl = i_work.cyl;
        n_work.rem = c_rem;
        n_work.quo = c_quo;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_work  = r_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_work <= n_work;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import lcc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int PIPE_LATENCY = 11;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int PHASE_COUNT = 12;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [CYL_COUNT_W-1:0]  cylinder;
        logic [HEAD_COUNT_W-1:0] head;
        logic [SPT_W-1:0]        sector;
        logic                    clamped;
    } t_chs;

    class chs_checker;
        logic [CYL_COUNT_W-1:0]  cyl_count;
        logic [HEAD_COUNT_W-1:0] head_count;
        logic [SPT_W-1:0]        spt;
        t_chs                    expected_chs_q[$];
        int                      mismatches;

        function new();
            cyl_count  = CYL_COUNT_RST;
            head_count = HEAD_COUNT_RST;
            spt        = SPT_RST;
            mismatches = 0;
        endfunction

        function void write_geometry(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CYL_COUNT:  cyl_count  = data[CYL_COUNT_W-1:0];
                CFG_HEAD_COUNT: head_count = data[HEAD_COUNT_W-1:0];
                CFG_SPT:        spt        = data[SPT_W-1:0];
                default: ;
            endcase
        endfunction

        function t_chs translate(logic [BLOCK_ADDRESS_W-1:0] addr);
            longint unsigned lba;
            longint unsigned per_cyl;
            longint unsigned cyl;
            longint unsigned rem;
            t_chs            r;
            lba = 64'(addr) & ((64'd1 << LBA_W) - 64'd1);
            r.cylinder = cyl_count;
            r.head     = head_count;
            r.sector   = spt;
            r.clamped  = 1'b1;
            if (head_count == 0 || spt == 0) return r;
            per_cyl = 64'(head_count) * 64'(spt);
            cyl = lba / per_cyl;
            if (cyl > 64'(cyl_count)) return r;
            rem = lba % per_cyl;
            r.cylinder = CYL_COUNT_W'(cyl);
            r.head     = HEAD_COUNT_W'(rem / 64'(spt));
            r.sector   = SPT_W'((rem % 64'(spt)) + 64'd1);
            r.clamped  = 1'b0;
            return r;
        endfunction

        function void note_address(logic [BLOCK_ADDRESS_W-1:0] addr);
            expected_chs_q.push_back(translate(addr));
        endfunction

        function void check_result(t_chs got);
            t_chs exp_chs;
            if (expected_chs_q.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected beat: cyl %0d head %0d sec %0d clamped %0d",
                             got.cylinder, got.head, got.sector, got.clamped);
                mismatches++;
                return;
            end
            exp_chs = expected_chs_q.pop_front();
            if (got.cylinder !== exp_chs.cylinder || got.head !== exp_chs.head ||
                got.sector !== exp_chs.sector || got.clamped !== exp_chs.clamped) begin
                if (mismatches < MAX_REPORTS)
                    $display("mismatch: exp cyl %0d head %0d sec %0d clamped %0d, got %0d %0d %0d %0d",
                             exp_chs.cylinder, exp_chs.head, exp_chs.sector, exp_chs.clamped,
                             got.cylinder, got.head, got.sector, got.clamped);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_chs_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    lcc_cfg_if cfg_bus ();
    lcc_lba_if lba_bus ();
    lcc_chs_if chs_bus ();

    lba_to_chs_geometry_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_lba   (lba_bus),
        .o_chs   (chs_bus)
    );

    chs_checker sb = new();

    bit src_idle;
    bit sink_idle;
    int sink_wait;
    int long_hold;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // result side: ready is driven at the falling edge, beats checked at the rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            chs_bus.ready = 1'b0;
        end else if (long_hold > 0) begin
            chs_bus.ready = 1'b0;
            long_hold--;
        end else if (sink_wait > 0) begin
            chs_bus.ready = 1'b0;
            sink_wait--;
        end else begin
            chs_bus.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_chs got;
        if (i_rst_n && chs_bus.valid && chs_bus.ready) begin
            got.cylinder = chs_bus.cylinder;
            got.head     = chs_bus.head;
            got.sector   = chs_bus.sector;
            got.clamped  = chs_bus.clamped;
            sb.check_result(got);
            sink_wait = sink_idle ? $urandom_range(0, 16) : 0;
        end
    end

    task automatic send_lba(input logic [BLOCK_ADDRESS_W-1:0] addr);
        int gap;
        gap = src_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            lba_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        lba_bus.valid = 1'b1;
        lba_bus.block_address = addr;
        do @(posedge i_clk); while (!lba_bus.ready);
        sb.note_address(addr);
        @(negedge i_clk);
        lba_bus.valid = 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.write_geometry(idx, data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic wait_all_results();
        lba_bus.valid = 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned cc, input int unsigned hd,
                                input int unsigned sp);
        write_reg(CFG_CYL_COUNT, CFG_DATA_W'(cc));
        write_reg(CFG_HEAD_COUNT, CFG_DATA_W'(hd) | (CFG_DATA_W'($urandom) & 16'hFF00));
        write_reg(CFG_SPT, CFG_DATA_W'(sp) | (CFG_DATA_W'($urandom) & 16'hFFC0));
    endtask

    // mostly addresses inside the disk, some around the last cylinder, some at edge values, some anywhere
    function automatic logic [BLOCK_ADDRESS_W-1:0] pick_lba();
        longint unsigned pc;
        longint unsigned span;
        longint unsigned lo;
        longint unsigned v;
        int unsigned     mode;
        pc = 64'(sb.head_count) * 64'(sb.spt);
        mode = $urandom_range(0, 99);
        if (pc == 0 || mode >= 85) return $urandom;
        span = (64'(sb.cyl_count) + 64'd1) * pc;
        if (mode < 55) begin
            v = $urandom_range(0, 32'(span - 64'd1));
        end else if (mode < 75) begin
            lo = (span > 2 * pc) ? span - 2 * pc : 64'd0;
            v = lo + $urandom_range(0, 32'(4 * pc));
        end else begin
            case ($urandom_range(0, 5))
                0: v = 64'd0;
                1: v = 64'hFFFF_FFFF;
                2: v = span - 64'd1;
                3: v = span;
                4: v = pc - 64'd1;
                default: v = 64'(sb.cyl_count) * pc;
            endcase
        end
        return BLOCK_ADDRESS_W'(v);
    endfunction

    initial begin
        logic [BLOCK_ADDRESS_W-1:0] directed_lba[$];
        int unsigned cc;
        int unsigned hd;
        int unsigned sp;

        i_rst_n = 1'b0;
        lba_bus.valid = 1'b0;
        lba_bus.block_address = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_CYL_COUNT;
        cfg_bus.data = '0;
        src_idle = 1'b0;
        sink_idle = 1'b0;
        sink_wait = 0;
        long_hold = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // reset geometry 1024/16/63: 1008 sectors per cylinder
        directed_lba = '{32'd0, 32'd1, 32'd62, 32'd63, 32'd1007, 32'd1008,
                         32'd1032191, 32'd1032192, 32'd1033199, 32'd1033200,
                         32'd1033201, 32'h0000_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                         32'h8000_0000, 32'hFFFF_FFFF};
        foreach (directed_lba[i]) send_lba(directed_lba[i]);

        src_idle = 1'b1;
        sink_idle = 1'b1;
        repeat (150) send_lba(pick_lba());

        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_all_results();
            case (p)
                0: begin cc = 65535; hd = 255; sp = 63; end
                1: begin cc = 1; hd = 1; sp = 1; end
                3: begin cc = 0; hd = 16; sp = 63; end
                4: begin cc = 1024; hd = 0; sp = 63; end
                5: begin cc = 1024; hd = 16; sp = 0; end
                6: begin cc = 65535; hd = 1; sp = 1; end
                7: begin cc = 1; hd = 255; sp = 63; end
                default: begin
                    cc = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                    : $urandom_range(1, 64);
                    hd = $urandom_range(1, 255);
                    sp = $urandom_range(1, 63);
                end
            endcase
            set_geometry(cc, hd, sp);
            if (p == 3) write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));

            src_idle = $urandom_range(0, 1);
            sink_idle = $urandom_range(0, 1);
            if (p == 0) begin
                src_idle = 1'b0;
                sink_idle = 1'b0;
            end
            if (p == 2) begin
                // block the result side long enough for the pipe to back up
                src_idle = 1'b0;
                @(posedge i_clk);
                long_hold = LONG_HOLD_CYCLES;
                @(negedge i_clk);
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_lba(pick_lba());
                if (p == 8 && i == ITEMS_PER_PHASE / 2) wait_all_results();
            end
        end

        wait_all_results();
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
